### hw/rtl/mpst_pkg.sv
// Shared types, codes and decode helpers for the MessagePack stream tokenizer.
// No dependencies; mpst_skid, the top level and the checker use scoped names, tb imports it.
package mpst_pkg;

  localparam int unsigned MaxNestingDef = 256;
  localparam logic [8:0]  DepthLimitRst = 9'd256;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_HDR     = 2'd1,
    PH_EXTTYPE = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    K_NIL     = 4'd0,
    K_BOOL    = 4'd1,
    K_UINT    = 4'd2,
    K_INT     = 4'd3,
    K_F32     = 4'd4,
    K_F64     = 4'd5,
    K_STR     = 4'd6,
    K_BIN     = 4'd7,
    K_EXT     = 4'd8,
    K_ARRAY   = 4'd9,
    K_MAP     = 4'd10,
    K_PAYLOAD = 4'd11,
    K_ERROR   = 4'd12
  } kind_e;

  typedef enum logic [3:0] {
    ERR_OK      = 4'd0,
    ERR_TAG     = 4'd1,
    ERR_DEPTH   = 4'd2,
    ERR_SCALAR  = 4'd3,
    ERR_STR     = 4'd4,
    ERR_BIN     = 4'd5,
    ERR_EXT     = 4'd6,
    ERR_ARRAY   = 4'd7,
    ERR_MAP     = 4'd8,
    ERR_MISSING = 4'd9
  } err_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_LEAF,
    ACT_OPEN,
    ACT_BYTES,
    ACT_FAIL
  } act_e;

  typedef struct packed {
    kind_e             kind;
    logic [63:0]       value;
    logic [31:0]       length;
    logic signed [7:0] xtype;
    err_e              code;
    logic [8:0]        level;
    logic              done;
  } token_t;

  // Error code of the item family a tag opens.
  function automatic err_e family_code(input logic [7:0] t);
    err_e r;
    case (t) inside
      [8'hA0:8'hBF], [8'hD9:8'hDB]: r = ERR_STR;
      [8'hC4:8'hC6]:                r = ERR_BIN;
      [8'hC7:8'hC9], [8'hD4:8'hD8]: r = ERR_EXT;
      [8'h90:8'h9F], 8'hDC, 8'hDD:  r = ERR_ARRAY;
      [8'h80:8'h8F], 8'hDE, 8'hDF:  r = ERR_MAP;
      default:                      r = ERR_SCALAR;
    endcase
    return r;
  endfunction

  // Number of big-endian header bytes after a tag.
  function automatic logic [3:0] header_len(input logic [7:0] t);
    logic [3:0] r;
    case (t) inside
      8'hC4, 8'hC7, 8'hCC, 8'hD0, 8'hD9:               r = 4'd1;
      8'hC5, 8'hC8, 8'hCD, 8'hD1, 8'hDA, 8'hDC, 8'hDE: r = 4'd2;
      8'hC6, 8'hC9, 8'hCA, 8'hCE, 8'hD2, 8'hDB, 8'hDD, 8'hDF: r = 4'd4;
      default:                                          r = 4'd8;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/mpst_ifs.sv
// Channel interfaces of the tokenizer: byte input, token output, config write.
// Depends on mpst_pkg for nothing but kept after it in compile order.
interface mpst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;
  modport source (output valid, in_byte, end_of_data, input ready);
  modport sink   (input valid, in_byte, end_of_data, output ready);
endinterface

interface mpst_tok_if;
  logic              valid;
  logic              ready;
  logic [3:0]        token_kind;
  logic [63:0]       token_value;
  logic [31:0]       token_length;
  logic signed [7:0] extension_type;
  logic [3:0]        error_code;
  logic [8:0]        nest_level;
  logic              object_done;
  modport source (output valid, token_kind, token_value, token_length, extension_type,
                  error_code, nest_level, object_done, input ready);
  modport sink   (input valid, token_kind, token_value, token_length, extension_type,
                  error_code, nest_level, object_done, output ready);
endinterface

interface mpst_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] depth_limit;
  modport source (output valid, depth_limit, input ready);
  modport sink   (input valid, depth_limit, output ready);
endinterface

### hw/rtl/mpst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mpst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/mpst_skid.sv
// Two-entry output buffer for tokens: output register plus skid register.
// Depends on mpst_pkg for token_t.
module mpst_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mpst_pkg::token_t tok_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            ready_i,
  output mpst_pkg::token_t tok_o
);
  logic             out_v_q, out_v_d, skid_v_q, skid_v_d;
  mpst_pkg::token_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || ready_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = push_i;
        skid_d   = tok_i;
      end else begin
        out_v_d = push_i;
        out_d   = tok_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_v_q;
  assign valid_o = out_v_q;
  assign tok_o   = out_q;
endmodule

### hw/rtl/messagepack_stream_tokenizer.sv
// Top level of the MessagePack stream tokenizer: byte parser, nesting stack
// in RAM with a cached top entry, and output buffer. Uses mpst_pkg, mpst_ifs,
// mpst_ram and mpst_skid.
//
//  channel | dir | handshake     | request carries
//  --------+-----+---------------+-----------------------------------------
//  in_i    | in  | valid/ready   | in_byte, end_of_data
//  tok_o   | out | valid/ready   | one token (kind, value, length, ...)
//  cfg_i   | in  | valid/ready   | depth_limit (ready is always high)
//
// One byte is taken every cycle while in_i.ready is high; each token is registered
// in the output buffer and leaves on tok_o from there. The stack top is held in a
// register; the entry below it comes back from the stack RAM in the cycle after a pop.
// Reset is asynchronous, active low; the stack RAM needs no clearing.
// in_i.ready drops only while both output buffer entries hold tokens.
module messagepack_stream_tokenizer #(
  parameter int unsigned MAX_NESTING = mpst_pkg::MaxNestingDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpst_in_if.sink    in_i,
  mpst_tok_if.source tok_o,
  mpst_cfg_if.sink   cfg_i
);
  localparam int unsigned AW  = MAX_NESTING > 1 ? $clog2(MAX_NESTING) : 1;
  localparam int unsigned SPW = $clog2(MAX_NESTING + 1);
  localparam int unsigned CW  = SPW > 9 ? SPW : 9;
  localparam int unsigned RW  = 33 + SPW;

  // Each stack entry holds the elements still owed and the stack pointer to
  // return to when it closes (ancestors that close along with it are skipped).
  mpst_pkg::phase_e phase_q, phase_d;
  logic [7:0]       tag_q, tag_d;
  logic [63:0]      acc_q, acc_d;
  logic [3:0]       hbl_q, hbl_d;
  logic [31:0]      pbl_q, pbl_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic             disc_q, disc_d;
  logic [8:0]       dlim_q;
  logic [32:0]      top_cnt_q, top_cnt_d;
  logic [SPW-1:0]   top_pop_q, top_pop_d;
  logic             use_ram_q, use_ram_d;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [RW-1:0]    wdata, rdata;

  logic             fire, push, full;
  mpst_pkg::token_t res;

  assign fire       = in_i.valid && in_i.ready;
  assign in_i.ready = !full;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    mpst_pkg::act_e   act;
    mpst_pkg::kind_e  a_kind;
    logic [63:0]      a_val;
    logic [31:0]      a_len;
    logic [32:0]      a_cnt;
    logic [7:0]       a_ext;
    mpst_pkg::err_e   a_code;
    logic [7:0]       b;
    logic             eod;
    logic [CW-1:0]    lvl_w;
    logic [32:0]      eff_cnt, c1;
    logic [SPW-1:0]   eff_pop, sp_new;
    logic [63:0]      acc_n, sx;
    logic [3:0]       hbl_n;
    logic [31:0]      pbl_n;
    logic [7:0]       diff;
    logic             done;

    b       = in_i.in_byte;
    eod     = in_i.end_of_data;
    lvl_w   = CW'(sp_q);
    eff_cnt = use_ram_q ? rdata[RW-1:SPW] : top_cnt_q;
    eff_pop = use_ram_q ? rdata[SPW-1:0] : top_pop_q;

    act    = mpst_pkg::ACT_NONE;
    a_kind = mpst_pkg::K_NIL;
    a_val  = '0;
    a_len  = '0;
    a_cnt  = '0;
    a_ext  = '0;
    a_code = mpst_pkg::ERR_OK;
    acc_n  = '0;
    hbl_n  = '0;
    pbl_n  = '0;
    diff   = '0;
    sx     = '0;
    c1     = '0;
    sp_new = sp_q;
    done   = 1'b0;

    phase_d   = phase_q;
    tag_d     = tag_q;
    acc_d     = acc_q;
    hbl_d     = hbl_q;
    pbl_d     = pbl_q;
    sp_d      = sp_q;
    disc_d    = disc_q;
    top_cnt_d = eff_cnt;
    top_pop_d = eff_pop;
    use_ram_d = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;
    push      = 1'b0;
    res       = '0;

    if (fire && disc_q) begin
      // drop bytes until the marked last one
      if (eod) begin
        disc_d  = 1'b0;
        phase_d = mpst_pkg::PH_TAG;
        tag_d   = '0;
        acc_d   = '0;
        hbl_d   = '0;
        pbl_d   = '0;
        sp_d    = '0;
      end
    end else if (fire) begin
      unique case (phase_q)
        mpst_pkg::PH_HDR: begin
          acc_n = {acc_q[55:0], b};
          hbl_n = (hbl_q != 4'd0) ? hbl_q - 4'd1 : 4'd0;
          acc_d = acc_n;
          hbl_d = hbl_n;
          if (hbl_n != 4'd0) begin
            if (eod) begin
              act    = mpst_pkg::ACT_FAIL;
              a_code = mpst_pkg::family_code(tag_q);
            end
          end else begin
            phase_d = mpst_pkg::PH_TAG;
            case (tag_q) inside
              8'hCA: begin
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_F32;
                a_val = {32'd0, acc_n[31:0]};
              end
              8'hCB: begin
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_F64; a_val = acc_n;
              end
              [8'hCC:8'hCF]: begin
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_UINT; a_val = acc_n;
              end
              [8'hD0:8'hD3]: begin
                case (tag_q[1:0])
                  2'd0:    sx = {{56{acc_n[7]}}, acc_n[7:0]};
                  2'd1:    sx = {{48{acc_n[15]}}, acc_n[15:0]};
                  2'd2:    sx = {{32{acc_n[31]}}, acc_n[31:0]};
                  default: sx = acc_n;
                endcase
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_INT; a_val = sx;
              end
              [8'hC4:8'hC6]: begin
                act = mpst_pkg::ACT_BYTES; a_kind = mpst_pkg::K_BIN; a_len = acc_n[31:0];
              end
              [8'hD9:8'hDB]: begin
                act = mpst_pkg::ACT_BYTES; a_kind = mpst_pkg::K_STR; a_len = acc_n[31:0];
              end
              [8'hC7:8'hC9]: begin
                pbl_d   = acc_n[31:0];
                phase_d = mpst_pkg::PH_EXTTYPE;
                if (eod) begin
                  act    = mpst_pkg::ACT_FAIL;
                  a_code = mpst_pkg::ERR_EXT;
                end
              end
              8'hDC, 8'hDD: begin
                act = mpst_pkg::ACT_OPEN; a_kind = mpst_pkg::K_ARRAY;
                a_len = acc_n[31:0]; a_cnt = {1'b0, acc_n[31:0]};
              end
              default: begin
                act = mpst_pkg::ACT_OPEN; a_kind = mpst_pkg::K_MAP;
                a_len = acc_n[31:0]; a_cnt = {acc_n[31:0], 1'b0};
              end
            endcase
          end
        end
        mpst_pkg::PH_EXTTYPE: begin
          phase_d = mpst_pkg::PH_TAG;
          act     = mpst_pkg::ACT_BYTES;
          a_kind  = mpst_pkg::K_EXT;
          a_len   = pbl_q;
          a_ext   = b;
        end
        mpst_pkg::PH_PAYLOAD: begin
          pbl_n  = (pbl_q != 32'd0) ? pbl_q - 32'd1 : 32'd0;
          pbl_d  = pbl_n;
          a_kind = mpst_pkg::K_PAYLOAD;
          a_val  = {56'd0, b};
          if (pbl_n == 32'd0) begin
            phase_d = mpst_pkg::PH_TAG;
            act     = mpst_pkg::ACT_LEAF;
          end else if (eod) begin
            act    = mpst_pkg::ACT_FAIL;
            a_code = mpst_pkg::family_code(tag_q);
          end else begin
            act = mpst_pkg::ACT_EMIT;
          end
        end
        default: begin
          phase_d = mpst_pkg::PH_TAG;
          if (lvl_w >= CW'(dlim_q) || sp_q >= SPW'(MAX_NESTING)) begin
            act    = mpst_pkg::ACT_FAIL;
            a_code = mpst_pkg::ERR_DEPTH;
          end else begin
            tag_d = b;
            acc_d = '0;
            case (b) inside
              [8'h00:8'h7F]: begin
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_UINT; a_val = {56'd0, b};
              end
              [8'hE0:8'hFF]: begin
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_INT; a_val = {56'hFF_FFFF_FFFF_FFFF, b};
              end
              [8'h80:8'h8F]: begin
                act = mpst_pkg::ACT_OPEN; a_kind = mpst_pkg::K_MAP;
                a_len = {28'd0, b[3:0]}; a_cnt = {28'd0, b[3:0], 1'b0};
              end
              [8'h90:8'h9F]: begin
                act = mpst_pkg::ACT_OPEN; a_kind = mpst_pkg::K_ARRAY;
                a_len = {28'd0, b[3:0]}; a_cnt = {29'd0, b[3:0]};
              end
              [8'hA0:8'hBF]: begin
                act = mpst_pkg::ACT_BYTES; a_kind = mpst_pkg::K_STR; a_len = {27'd0, b[4:0]};
              end
              8'hC0: begin
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_NIL;
              end
              8'hC1: begin
                act = mpst_pkg::ACT_FAIL; a_code = mpst_pkg::ERR_TAG;
              end
              8'hC2, 8'hC3: begin
                act = mpst_pkg::ACT_LEAF; a_kind = mpst_pkg::K_BOOL; a_val = {63'd0, b[0]};
              end
              [8'hD4:8'hD8]: begin
                diff    = b - 8'hD4;
                pbl_d   = 32'd1 << diff[2:0];
                phase_d = mpst_pkg::PH_EXTTYPE;
                if (eod) begin
                  act = mpst_pkg::ACT_FAIL; a_code = mpst_pkg::ERR_EXT;
                end
              end
              default: begin
                hbl_d   = mpst_pkg::header_len(b);
                phase_d = mpst_pkg::PH_HDR;
                if (eod) begin
                  act = mpst_pkg::ACT_FAIL; a_code = mpst_pkg::family_code(b);
                end
              end
            endcase
          end
        end
      endcase

      // empty containers and empty byte strings complete at their header
      if (act == mpst_pkg::ACT_OPEN && a_cnt == 33'd0) begin
        act = mpst_pkg::ACT_LEAF;
      end
      if (act == mpst_pkg::ACT_BYTES && a_len == 32'd0) begin
        act = mpst_pkg::ACT_LEAF;
      end

      res.kind     = a_kind;
      res.value    = a_val;
      res.length   = a_len;
      res.xtype    = a_ext;
      res.code     = mpst_pkg::ERR_OK;
      res.level    = lvl_w[8:0];
      res.done     = 1'b0;

      case (act)
        mpst_pkg::ACT_EMIT: begin
          push = 1'b1;
        end
        mpst_pkg::ACT_LEAF: begin
          // count the item against the stack top, pop on zero
          if (sp_q == '0) begin
            done = 1'b1;
          end else begin
            c1 = eff_cnt - 33'd1;
            if (c1 != 33'd0) begin
              top_cnt_d = c1;
            end else begin
              sp_new = eff_pop;
              done   = (eff_pop == '0);
              if (eff_pop != '0) begin
                re        = 1'b1;
                raddr     = AW'(eff_pop - SPW'(1));
                use_ram_d = 1'b1;
              end
            end
          end
          if (eod && sp_new != '0) begin
            act    = mpst_pkg::ACT_FAIL;
            a_code = mpst_pkg::ERR_MISSING;
          end else begin
            sp_d     = sp_new;
            res.done = done;
            push     = 1'b1;
          end
        end
        mpst_pkg::ACT_OPEN: begin
          if (sp_q >= SPW'(MAX_NESTING)) begin
            act    = mpst_pkg::ACT_FAIL;
            a_code = mpst_pkg::ERR_DEPTH;
          end else begin
            // the container counts against its parent right away
            if (sp_q != '0) begin
              c1        = eff_cnt - 33'd1;
              we        = 1'b1;
              waddr     = AW'(sp_q - SPW'(1));
              wdata     = {c1, eff_pop};
              top_pop_d = (c1 == 33'd0) ? eff_pop : sp_q;
            end else begin
              top_pop_d = '0;
            end
            top_cnt_d = a_cnt;
            sp_d      = sp_q + SPW'(1);
            if (eod) begin
              act    = mpst_pkg::ACT_FAIL;
              a_code = mpst_pkg::ERR_MISSING;
            end else begin
              res.value = '0;
              push      = 1'b1;
            end
          end
        end
        mpst_pkg::ACT_BYTES: begin
          pbl_d   = a_len;
          phase_d = mpst_pkg::PH_PAYLOAD;
          if (eod) begin
            act    = mpst_pkg::ACT_FAIL;
            a_code = mpst_pkg::family_code(tag_d);
          end else begin
            res.value = '0;
            push      = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (act == mpst_pkg::ACT_FAIL) begin
        // clear parse state and the stack; discard unless this byte ends the data
        res          = '0;
        res.kind     = mpst_pkg::K_ERROR;
        res.code     = a_code;
        res.level    = lvl_w[8:0];
        push         = 1'b1;
        phase_d      = mpst_pkg::PH_TAG;
        tag_d        = '0;
        acc_d        = '0;
        hbl_d        = '0;
        pbl_d        = '0;
        sp_d         = '0;
        disc_d       = !eod;
        re           = 1'b0;
        use_ram_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mpst_pkg::PH_TAG;
      tag_q     <= '0;
      acc_q     <= '0;
      hbl_q     <= '0;
      pbl_q     <= '0;
      sp_q      <= '0;
      disc_q    <= 1'b0;
      dlim_q    <= mpst_pkg::DepthLimitRst;
      use_ram_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      tag_q     <= tag_d;
      acc_q     <= acc_d;
      hbl_q     <= hbl_d;
      pbl_q     <= pbl_d;
      sp_q      <= sp_d;
      disc_q    <= disc_d;
      use_ram_q <= use_ram_d;
      if (cfg_i.valid && cfg_i.ready) begin
        dlim_q <= cfg_i.depth_limit;
      end
    end
  end

  // hold the stack top in a register
  always_ff @(posedge clk_i) begin
    top_cnt_q <= top_cnt_d;
    top_pop_q <= top_pop_d;
  end

  mpst_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_NESTING)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  mpst_pkg::token_t tok;

  mpst_skid u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok_i  (res),
    .full_o (full),
    .valid_o(tok_o.valid),
    .ready_i(tok_o.ready),
    .tok_o  (tok)
  );

  assign tok_o.token_kind     = tok.kind;
  assign tok_o.token_value    = tok.value;
  assign tok_o.token_length   = tok.length;
  assign tok_o.extension_type = tok.xtype;
  assign tok_o.error_code     = tok.code;
  assign tok_o.nest_level     = tok.level;
  assign tok_o.object_done    = tok.done;

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(MAX_NESTING))
    else $error("stack pointer beyond nesting depth");

  a_refill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_ram_q |-> sp_q != '0)
    else $error("stack top refill with empty stack");

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && disc_q) |-> !push)
    else $error("token produced while discarding");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("stack push and pop in one cycle");
`endif
endmodule

### verif/mpst_tb_ifs.sv
`timescale 1ns / 1ps
// Shared constants of the bench; the channel interfaces come from hw/rtl/mpst_ifs.sv.
// No dependencies.
package mpst_tb_pkg;
  localparam int ReportLimit = 10;
endpackage

### verif/mpst_token_checker.sv
`timescale 1ns / 1ps
// Token checker: watches the byte, token and config channels, predicts each token
// from accepted requests and compares every field. Depends on mpst_pkg and mpst_tb_pkg.
module mpst_token_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_eod_i,
  input  logic       tok_valid_i,
  input  logic       tok_ready_i,
  input  mpst_pkg::token_t tok_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [8:0] cfg_data_i,
  output int         fail_count_o,
  output int         tokens_owed_o
);
  import mpst_pkg::*;

  localparam int Nest = int'(mpst_pkg::MaxNestingDef);

  token_t      token_queue[$];
  logic [8:0]  lim;
  phase_e      phase;
  logic [7:0]  tag;
  logic [63:0] acc;
  logic [3:0]  hdr_left;
  logic [31:0] pay_left;
  logic [32:0] owed [Nest];
  logic [8:0]  sp;
  logic        dropping;
  logic        have;
  token_t      tk;

  function automatic err_e tag_family(input logic [7:0] t);
    if ((t >= 8'hA0 && t <= 8'hBF) || (t >= 8'hD9 && t <= 8'hDB)) return ERR_STR;
    if (t >= 8'hC4 && t <= 8'hC6) return ERR_BIN;
    if ((t >= 8'hC7 && t <= 8'hC9) || (t >= 8'hD4 && t <= 8'hD8)) return ERR_EXT;
    if ((t >= 8'h90 && t <= 8'h9F) || t == 8'hDC || t == 8'hDD) return ERR_ARRAY;
    if ((t >= 8'h80 && t <= 8'h8F) || t == 8'hDE || t == 8'hDF) return ERR_MAP;
    return ERR_SCALAR;
  endfunction

  function automatic logic [3:0] tag_hdr_bytes(input logic [7:0] t);
    case (t)
      8'hC4, 8'hC7, 8'hCC, 8'hD0, 8'hD9: return 4'd1;
      8'hC5, 8'hC8, 8'hCD, 8'hD1, 8'hDA, 8'hDC, 8'hDE: return 4'd2;
      8'hC6, 8'hC9, 8'hCA, 8'hCE, 8'hD2, 8'hDB, 8'hDD, 8'hDF: return 4'd4;
      default: return 4'd8;
    endcase
  endfunction

  task automatic clear_parse();
    phase = PH_TAG; tag = '0; acc = '0; hdr_left = '0; pay_left = '0; sp = '0;
  endtask

  task automatic put(input kind_e k, input logic [63:0] v, input logic [31:0] l,
                     input logic [7:0] x, input err_e e, input logic [8:0] lv,
                     input logic d);
    tk.kind = k; tk.value = v; tk.length = l; tk.xtype = x; tk.code = e;
    tk.level = lv; tk.done = d; have = 1'b1;
  endtask

  task automatic raise(input err_e e, input logic [8:0] lv, input logic eod);
    put(K_ERROR, '0, '0, '0, e, lv, 1'b0);
    clear_parse();
    dropping = !eod;
  endtask

  // Count a finished item against the open containers; 1 when top level ends.
  function automatic logic close_item();
    logic [32:0] c;
    while (sp != 0) begin
      c = owed[sp - 1] - 1'b1;
      if (c != 0) begin
        owed[sp - 1] = c;
        return 1'b0;
      end
      sp = sp - 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic leaf(input kind_e k, input logic [63:0] v, input logic [31:0] l,
                      input logic [7:0] x, input logic [8:0] lv, input logic eod);
    logic d;
    d = close_item();
    if (eod && sp != 0) raise(ERR_MISSING, lv, eod);
    else put(k, v, l, x, ERR_OK, lv, d);
  endtask

  task automatic open_box(input kind_e k, input logic [31:0] l, input logic [32:0] n,
                          input logic [8:0] lv, input logic eod);
    if (n == 0) leaf(k, '0, l, '0, lv, eod);
    else if (lv >= Nest) raise(ERR_DEPTH, lv, eod);
    else begin
      owed[lv] = n;
      sp = lv + 1'b1;
      if (eod) raise(ERR_MISSING, lv, eod);
      else put(k, '0, l, '0, ERR_OK, lv, 1'b0);
    end
  endtask

  task automatic start_bytes(input kind_e k, input logic [31:0] l, input logic [7:0] x,
                             input logic [8:0] lv, input logic eod);
    if (l == 0) leaf(k, '0, '0, x, lv, eod);
    else begin
      pay_left = l;
      phase = PH_PAYLOAD;
      if (eod) raise(tag_family(tag), lv, eod);
      else put(k, '0, l, x, ERR_OK, lv, 1'b0);
    end
  endtask

  task automatic finish_header(input logic [8:0] lv, input logic eod);
    logic [63:0] a;
    int bits;
    a = acc;
    phase = PH_TAG;
    if (tag == 8'hCA) leaf(K_F32, {32'd0, a[31:0]}, '0, '0, lv, eod);
    else if (tag == 8'hCB) leaf(K_F64, a, '0, '0, lv, eod);
    else if (tag >= 8'hCC && tag <= 8'hCF) leaf(K_UINT, a, '0, '0, lv, eod);
    else if (tag >= 8'hD0 && tag <= 8'hD3) begin
      bits = 8 << (tag - 8'hD0);
      if (bits < 64 && a[bits - 1]) a = a | ~((64'd1 << bits) - 1);
      leaf(K_INT, a, '0, '0, lv, eod);
    end
    else if (tag >= 8'hC4 && tag <= 8'hC6) start_bytes(K_BIN, a[31:0], '0, lv, eod);
    else if (tag >= 8'hD9 && tag <= 8'hDB) start_bytes(K_STR, a[31:0], '0, lv, eod);
    else if (tag >= 8'hC7 && tag <= 8'hC9) begin
      pay_left = a[31:0];
      phase = PH_EXTTYPE;
      if (eod) raise(ERR_EXT, lv, eod);
    end
    else if (tag == 8'hDC || tag == 8'hDD) open_box(K_ARRAY, a[31:0], {1'b0, a[31:0]}, lv, eod);
    else open_box(K_MAP, a[31:0], {a[31:0], 1'b0}, lv, eod);
  endtask

  task automatic take_tag(input logic [7:0] b, input logic [8:0] lv, input logic eod);
    logic [8:0] cap;
    cap = (lim < Nest) ? lim : 9'(Nest);
    if (lv >= cap) begin
      raise(ERR_DEPTH, lv, eod);
      return;
    end
    tag = b;
    acc = '0;
    if (b <= 8'h7F) leaf(K_UINT, {56'd0, b}, '0, '0, lv, eod);
    else if (b >= 8'hE0) leaf(K_INT, {56'hFFFFFFFFFFFFFF, b}, '0, '0, lv, eod);
    else if (b <= 8'h8F) open_box(K_MAP, {28'd0, b[3:0]}, {28'd0, b[3:0], 1'b0}, lv, eod);
    else if (b <= 8'h9F) open_box(K_ARRAY, {28'd0, b[3:0]}, {29'd0, b[3:0]}, lv, eod);
    else if (b <= 8'hBF) start_bytes(K_STR, {27'd0, b[4:0]}, '0, lv, eod);
    else if (b == 8'hC0) leaf(K_NIL, '0, '0, '0, lv, eod);
    else if (b == 8'hC1) raise(ERR_TAG, lv, eod);
    else if (b == 8'hC2 || b == 8'hC3) leaf(K_BOOL, {63'd0, b[0]}, '0, '0, lv, eod);
    else if (b >= 8'hD4 && b <= 8'hD8) begin
      pay_left = 32'd1 << (b - 8'hD4);
      phase = PH_EXTTYPE;
      if (eod) raise(ERR_EXT, lv, eod);
    end
    else begin
      hdr_left = tag_hdr_bytes(b);
      phase = PH_HDR;
      if (eod) raise(tag_family(b), lv, eod);
    end
  endtask

  // Advance the predicted tokenizer by one accepted byte.
  task automatic tokenize_byte(input logic [7:0] b, input logic eod);
    logic [8:0] lv;
    lv = sp;
    have = 1'b0;
    if (dropping) begin
      if (eod) begin
        clear_parse();
        dropping = 1'b0;
      end
      return;
    end
    case (phase)
      PH_HDR: begin
        acc = {acc[55:0], b};
        if (hdr_left > 0) hdr_left = hdr_left - 1'b1;
        if (hdr_left != 0) begin
          if (eod) raise(tag_family(tag), lv, eod);
        end else finish_header(lv, eod);
      end
      PH_EXTTYPE: begin
        phase = PH_TAG;
        start_bytes(K_EXT, pay_left, b, lv, eod);
      end
      PH_PAYLOAD: begin
        if (pay_left > 0) pay_left = pay_left - 1'b1;
        if (pay_left == 0) begin
          phase = PH_TAG;
          leaf(K_PAYLOAD, {56'd0, b}, '0, '0, lv, eod);
        end else if (eod) raise(tag_family(tag), lv, eod);
        else put(K_PAYLOAD, {56'd0, b}, '0, '0, ERR_OK, lv, 1'b0);
      end
      default: take_tag(b, lv, eod);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_t exp_tok;
    if (!rst_ni) begin
      lim = 9'd256;
      dropping = 1'b0;
      clear_parse();
      token_queue.delete();
      fail_count_o <= 0;
    end else begin
      // Compare first: a token cannot come out in the cycle its byte enters.
      if (tok_valid_i && tok_ready_i) begin
        if (token_queue.size() == 0) begin
          if (fail_count_o < mpst_tb_pkg::ReportLimit)
            $display("%0t: unexpected token kind %0d (expected none)", $realtime, tok_i.kind);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_tok = token_queue.pop_front();
          if (tok_i !== exp_tok) begin
            if (fail_count_o < mpst_tb_pkg::ReportLimit)
              $display({"%0t: token mismatch exp k%0d v%h l%h x%h e%0d n%0d d%0d",
                        " got k%0d v%h l%h x%h e%0d n%0d d%0d"},
                $realtime, exp_tok.kind, exp_tok.value, exp_tok.length, exp_tok.xtype,
                exp_tok.code, exp_tok.level, exp_tok.done, tok_i.kind, tok_i.value,
                tok_i.length, tok_i.xtype, tok_i.code, tok_i.level, tok_i.done);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) lim = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        tokenize_byte(in_byte_i, in_eod_i);
        if (have) token_queue.push_back(tk);
      end
    end
    tokens_owed_o = token_queue.size();
  end
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the tokenizer bench: clock, reset, byte-stream stimulus with random gaps,
// config writes between phases and the verdict. Depends on mpst_pkg, mpst_ifs, checker.
module tb;
  import mpst_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   tokens_owed;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  logic [7:0] msg_bytes[$];
  token_t tok_seen;

  mpst_in_if  in_ch();
  mpst_tok_if tok_ch();
  mpst_cfg_if cfg_ch();

  messagepack_stream_tokenizer uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .tok_o(tok_ch), .cfg_i(cfg_ch)
  );

  assign tok_seen = '{kind: kind_e'(tok_ch.token_kind), value: tok_ch.token_value,
                      length: tok_ch.token_length, xtype: tok_ch.extension_type,
                      code: err_e'(tok_ch.error_code), level: tok_ch.nest_level,
                      done: tok_ch.object_done};

  mpst_token_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .in_byte_i(in_ch.in_byte), .in_eod_i(in_ch.end_of_data),
    .tok_valid_i(tok_ch.valid), .tok_ready_i(tok_ch.ready), .tok_i(tok_seen),
    .cfg_valid_i(cfg_ch.valid), .cfg_ready_i(cfg_ch.ready), .cfg_data_i(cfg_ch.depth_limit),
    .fail_count_o(fail_count), .tokens_owed_o(tokens_owed)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop: sized for ~3000 bytes worst case with random gaps and stalls on both sides.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Token sink: before each token, hold ready low for a randomly drawn gap, which may be empty.
  initial begin
    int gap;
    tok_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        tok_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      tok_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!tok_ch.valid) @(posedge clk_i);
    end
  end

  // Send one request, waiting a random idle gap first; burst mode skips the gap.
  task automatic send_byte(input logic [7:0] b, input logic eod, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_data <= eod;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Flush the queued message; if mark_last is set, only its final byte is marked as last.
  task automatic send_msg(input bit mark_last);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    while (msg_bytes.size() != 0)
      send_byte(msg_bytes.pop_front(), mark_last && msg_bytes.size() == 0, burst);
  endtask

  task automatic push_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
  endtask

  // Append one random well-formed item, nesting up to the given depth.
  task automatic add_item(input int depth);
    int sel, n;
    logic [7:0] t;
    sel = $urandom_range(0, (depth > 0) ? 13 : 10);
    case (sel)
      0: msg_bytes.push_back(8'($urandom_range(0, 127)));
      1: msg_bytes.push_back(8'($urandom_range(224, 255)));
      2: begin
        t = 8'($urandom_range(192, 195));
        msg_bytes.push_back((t == 8'hC1) ? 8'hC0 : t);
      end
      3: begin
        t = 8'($urandom_range(8'hCA, 8'hD3));
        msg_bytes.push_back(t);
        n = (t == 8'hCA) ? 4 : (t == 8'hCB) ? 8 : 1 << (t < 8'hD0 ? t - 8'hCC : t - 8'hD0);
        push_be({$urandom, $urandom}, n);
      end
      4, 5: begin
        n = $urandom_range(0, 5);
        msg_bytes.push_back(8'hA0 | n[4:0]);
        repeat (n) msg_bytes.push_back(8'($urandom));
      end
      6: begin
        n = $urandom_range(0, 4);
        t = 8'hC4 + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) t = 8'hD9 + 8'($urandom_range(0, 2));
        msg_bytes.push_back(t);
        push_be(64'(n), (t == 8'hC4 || t == 8'hD9) ? 1 : (t == 8'hC5 || t == 8'hDA) ? 2 : 4);
        repeat (n) msg_bytes.push_back(8'($urandom));
      end
      7: begin
        t = 8'($urandom_range(8'hD4, 8'hD8));
        msg_bytes.push_back(t);
        msg_bytes.push_back(8'($urandom));
        repeat (1 << (t - 8'hD4)) msg_bytes.push_back(8'($urandom));
      end
      8: begin
        n = $urandom_range(0, 3);
        t = 8'hC7 + 8'($urandom_range(0, 2));
        msg_bytes.push_back(t);
        push_be(64'(n), t == 8'hC7 ? 1 : t == 8'hC8 ? 2 : 4);
        msg_bytes.push_back(8'($urandom));
        repeat (n) msg_bytes.push_back(8'($urandom));
      end
      9, 10: msg_bytes.push_back($urandom_range(0, 1) ? 8'h90 : 8'h80);
      11: begin
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) begin
          msg_bytes.push_back(8'hDC); push_be(64'(n), 2);
        end else msg_bytes.push_back(8'h90 | n[3:0]);
        repeat (n) add_item(depth - 1);
      end
      default: begin
        n = $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) begin
          msg_bytes.push_back(8'hDF); push_be(64'(n), 4);
        end else msg_bytes.push_back(8'h80 | n[3:0]);
        repeat (2 * n) add_item(depth - 1);
      end
    endcase
  endtask

  // Write the depth limit while idle: drain tokens, then allow the pipe to settle.
  task automatic write_limit(input logic [8:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tokens_owed != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.depth_limit <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random phase: mostly well-formed objects, some truncated, some corrupted or followed by a stray byte.
  task automatic random_phase(input int n_bytes, input int depth);
    int mode, cut;
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      msg_bytes.delete();
      repeat ($urandom_range(1, 3)) add_item(depth);
      mode = $urandom_range(0, 9);
      if (mode == 0 && msg_bytes.size() > 1) begin
        // Truncate: drop the bytes after a random point in the middle.
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end else if (mode == 1) begin
        // Corrupt one byte with a random value.
        msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
      end else if (mode == 2) begin
        msg_bytes.push_back(8'($urandom));
      end
      send_msg($urandom_range(0, 3) != 0);
    end
    // Close out any discard or partial item.
    send_byte(8'hC0, 1'b1, 1'b0);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.end_of_data <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.depth_limit <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: scalar extremes, nested containers with a string and an ext, errors and truncation.
    msg_bytes = '{8'h00, 8'h7F, 8'hE0, 8'hFF, 8'hC0, 8'hC2, 8'hC3,
                  8'hD3, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'hCF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_msg(1'b1);
    msg_bytes = '{8'h91, 8'h81, 8'hA0, 8'h90, 8'hC8, 8'h00, 8'h01, 8'h80, 8'h55};
    send_msg(1'b1);
    msg_bytes = '{8'hC1, 8'h11, 8'h22};
    send_msg(1'b1);
    msg_bytes = '{8'hCD, 8'h12};
    send_msg(1'b1);
    msg_bytes = '{8'h92, 8'h01};
    send_msg(1'b1);

    // Hold off until every token has come back.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tokens_owed != 0) @(posedge clk_i);

    write_limit(9'd1);
    msg_bytes = '{8'h91, 8'h91, 8'h01};
    send_msg(1'b1);
    random_phase(250, 2);
    write_limit(9'd0);
    random_phase(100, 1);
    write_limit(9'd3);
    random_phase(500, 4);
    write_limit(9'd511);
    random_phase(500, 5);
    write_limit(9'd256);
    random_phase(400, 3);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tokens_owed != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/mpst_pkg.sv
hw/rtl/mpst_ifs.sv
hw/rtl/mpst_ram.sv
hw/rtl/mpst_skid.sv
hw/rtl/messagepack_stream_tokenizer.sv
verif/mpst_tb_ifs.sv
verif/mpst_token_checker.sv
verif/tb.sv
